[rtl/single_wire_sensor_frame_receiver_defines.svh]
// Assertion macros shared by the single-wire sensor frame receiver.
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_DEFINES_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SWSFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swsfr_pkg.sv]
// Package with types, codes and constants of the single-wire sensor frame receiver.
`default_nettype none

package swsfr_pkg;

    localparam int FRAME_BYTES_DEFAULT = 5;

    localparam logic [7:0] IDLE_PERIODS_RESET  = 8'd13;
    localparam logic [7:0] ONE_THRESHOLD_RESET = 8'd48;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_PERIODS  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THRESHOLD = 1'd1;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TIMER = 2'd1;
    localparam logic [1:0] FUNC_EDGE  = 2'd2;

    localparam logic [1:0] TM_KEEP  = 2'd0;
    localparam logic [1:0] TM_IDLE  = 2'd1;
    localparam logic [1:0] TM_START = 2'd2;
    localparam logic [1:0] TM_EDGE  = 2'd3;

    typedef enum logic [2:0] {
        PH_WAIT      = 3'd0,
        PH_OUT_LOW   = 3'd1,
        PH_OUT_HIGH  = 3'd2,
        PH_IN_LOW    = 3'd3,
        PH_IN_HIGH   = 3'd4,
        PH_DATA_LOW  = 3'd5,
        PH_DATA_HIGH = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic       line_level;
        logic [7:0] edge_time;
    } evt_t;

    typedef struct packed {
        logic        line_drive_low;
        logic [1:0]  timer_mode;
        logic        edge_watch;
        logic        frame_valid;
        logic [31:0] reading;
        logic        checksum_fail;
        logic        protocol_error;
    } res_t;

    // Commands from the sequencer to the frame store.
    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_val;
    } frm_ctrl_t;

    // Status from the frame store back to the sequencer.
    typedef struct packed {
        logic done;
        logic sum_ok;
    } frm_stat_t;

endpackage

`default_nettype wire

[rtl/swsfr_frame.sv]
// Frame store: bit shift register, bit counter, checksum and reading extraction.
`default_nettype none

module swsfr_frame #(
    parameter int FRAME_BYTES = swsfr_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire swsfr_pkg::frm_ctrl_t ctrl,
    output swsfr_pkg::frm_stat_t      stat,
    output logic [31:0]               reading
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int RD_BYTES   = (FRAME_BYTES < 4) ? FRAME_BYTES : 4;

    logic [FRAME_BITS-1:0] shift_reg;
    logic [CNT_W-1:0]      bits_reg;
    logic [CNT_W-1:0]      bits_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W:0]        bits_inc;
    logic [7:0]            sum;

    assign bits_inc = {1'b0, bits_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        bits_next = bits_reg;
        done_next = done_reg;
        if (ctrl.clear)
        begin
            bits_next = '0;
            done_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            if (bits_inc >= (CNT_W+1)'(FRAME_BITS))
            begin
                bits_next = '0;
                done_next = 1'b1;
            end
            else
            begin
                bits_next = bits_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (en)
        begin
            bits_reg <= bits_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctrl.shift)
        begin
            shift_reg <= {shift_reg[FRAME_BITS-2:0], ctrl.bit_val};
        end
    end

    // Byte 0 is the first byte received and sits at the top of the shift register.
    always_comb
    begin
        sum = 8'd0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            sum = sum + shift_reg[8*(FRAME_BYTES-1-i) +: 8];
        end
    end

    always_comb
    begin
        reading = 32'd0;
        for (int j = 0; j < RD_BYTES; j++)
        begin
            reading[8*(3-j) +: 8] = shift_reg[8*(FRAME_BYTES-1-j) +: 8];
        end
    end

    assign stat.done   = done_reg;
    assign stat.sum_ok = (sum == shift_reg[7:0]);

endmodule

`default_nettype wire

[rtl/swsfr_ctrl.sv]
// Sequencer: exchange phase, idle countdown and per-request result decode.
`default_nettype none

module swsfr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire swsfr_pkg::evt_t      evt,
    input  wire logic [7:0]           idle_periods,
    input  wire logic [7:0]           one_threshold,
    input  wire swsfr_pkg::frm_stat_t stat,
    input  wire logic [31:0]          frame_reading,
    output swsfr_pkg::frm_ctrl_t      fctrl,
    output swsfr_pkg::res_t           res
);

    swsfr_pkg::phase_t phase_reg;
    swsfr_pkg::phase_t phase_next;
    logic [7:0]        idle_left_reg;
    logic [7:0]        idle_left_next;
    logic [7:0]        idle_dec;
    logic              edge_ok;

    assign idle_dec = idle_left_reg - 8'd1;

    // Whether a line edge shows the level that the current phase expects.
    always_comb
    begin
        case (phase_reg)
            swsfr_pkg::PH_OUT_HIGH:  edge_ok = !evt.line_level;
            swsfr_pkg::PH_IN_LOW:    edge_ok = evt.line_level;
            swsfr_pkg::PH_IN_HIGH:   edge_ok = !evt.line_level;
            swsfr_pkg::PH_DATA_LOW:  edge_ok = evt.line_level;
            swsfr_pkg::PH_DATA_HIGH: edge_ok = !evt.line_level;
            default:                 edge_ok = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next     = phase_reg;
        idle_left_next = idle_left_reg;
        case (evt.func)
            swsfr_pkg::FUNC_START:
            begin
                if (phase_reg == swsfr_pkg::PH_WAIT)
                begin
                    idle_left_next = idle_periods;
                end
            end
            swsfr_pkg::FUNC_TIMER:
            begin
                case (phase_reg)
                    swsfr_pkg::PH_WAIT:
                    begin
                        idle_left_next = idle_dec;
                        if (idle_dec == 8'd0)
                        begin
                            phase_next = swsfr_pkg::PH_OUT_LOW;
                        end
                    end
                    swsfr_pkg::PH_OUT_LOW:
                    begin
                        phase_next = swsfr_pkg::PH_OUT_HIGH;
                    end
                    default:
                    begin
                        phase_next     = swsfr_pkg::PH_WAIT;
                        idle_left_next = idle_periods;
                    end
                endcase
            end
            swsfr_pkg::FUNC_EDGE:
            begin
                if (!edge_ok)
                begin
                    phase_next     = swsfr_pkg::PH_WAIT;
                    idle_left_next = idle_periods;
                end
                else
                begin
                    case (phase_reg)
                        swsfr_pkg::PH_OUT_HIGH:  phase_next = swsfr_pkg::PH_IN_LOW;
                        swsfr_pkg::PH_IN_LOW:    phase_next = swsfr_pkg::PH_IN_HIGH;
                        swsfr_pkg::PH_IN_HIGH:   phase_next = swsfr_pkg::PH_DATA_LOW;
                        swsfr_pkg::PH_DATA_HIGH: phase_next = swsfr_pkg::PH_DATA_LOW;
                        swsfr_pkg::PH_DATA_LOW:
                        begin
                            if (stat.done)
                            begin
                                phase_next     = swsfr_pkg::PH_WAIT;
                                idle_left_next = idle_periods;
                            end
                            else
                            begin
                                phase_next = swsfr_pkg::PH_DATA_HIGH;
                            end
                        end
                        default:                 phase_next = phase_reg;
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Outputs of the decode: timer command, flags and frame store commands.
    always_comb
    begin
        res                = '0;
        fctrl              = '0;
        fctrl.bit_val      = (evt.edge_time >= one_threshold);
        case (evt.func)
            swsfr_pkg::FUNC_START:
            begin
                if (phase_reg == swsfr_pkg::PH_WAIT)
                begin
                    res.timer_mode = swsfr_pkg::TM_IDLE;
                end
            end
            swsfr_pkg::FUNC_TIMER:
            begin
                case (phase_reg)
                    swsfr_pkg::PH_WAIT:
                    begin
                        if (idle_dec == 8'd0)
                        begin
                            res.timer_mode = swsfr_pkg::TM_START;
                        end
                    end
                    swsfr_pkg::PH_OUT_LOW:
                    begin
                        res.timer_mode = swsfr_pkg::TM_EDGE;
                    end
                    default:
                    begin
                        res.timer_mode     = swsfr_pkg::TM_IDLE;
                        res.protocol_error = 1'b1;
                    end
                endcase
            end
            swsfr_pkg::FUNC_EDGE:
            begin
                if (!edge_ok)
                begin
                    res.timer_mode     = swsfr_pkg::TM_IDLE;
                    res.protocol_error = 1'b1;
                end
                else if (phase_reg == swsfr_pkg::PH_DATA_LOW && stat.done)
                begin
                    res.timer_mode    = swsfr_pkg::TM_IDLE;
                    res.frame_valid   = stat.sum_ok;
                    res.checksum_fail = !stat.sum_ok;
                    res.reading       = frame_reading;
                end
                else
                begin
                    res.timer_mode = swsfr_pkg::TM_EDGE;
                    fctrl.clear    = (phase_reg == swsfr_pkg::PH_IN_HIGH);
                    fctrl.shift    = (phase_reg == swsfr_pkg::PH_DATA_HIGH);
                end
            end
            default:
            begin
                res.timer_mode = swsfr_pkg::TM_KEEP;
            end
        endcase
        res.line_drive_low = (phase_next == swsfr_pkg::PH_OUT_LOW);
        res.edge_watch     = (phase_next == swsfr_pkg::PH_OUT_HIGH)
                          || (phase_next == swsfr_pkg::PH_IN_LOW)
                          || (phase_next == swsfr_pkg::PH_IN_HIGH)
                          || (phase_next == swsfr_pkg::PH_DATA_LOW)
                          || (phase_next == swsfr_pkg::PH_DATA_HIGH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= swsfr_pkg::PH_WAIT;
            idle_left_reg <= 8'd0;
        end
        else if (en)
        begin
            phase_reg     <= phase_next;
            idle_left_reg <= idle_left_next;
        end
    end

endmodule

`default_nettype wire

[rtl/single_wire_sensor_frame_receiver.sv]
// Top level of the single-wire sensor frame receiver: config registers and result register.
//
//  Channel   Direction  Handshake             Payload
//  evt       in         evt_valid / evt_stall swsfr_pkg::evt_t (func, line_level, edge_time)
//  res       out        res_valid / res_stall swsfr_pkg::res_t (one result per request)
//  cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request is decoded in the cycle it is accepted and its result appears in the
// result register on the next cycle; one request per cycle is sustained unless stalled.
// The decode path is the phase decode plus an eight-bit sum over the stored frame bytes.
// A request is taken whenever the result register is empty or being emptied.
// Reset clears the phase, counters and the result valid; config returns to its defaults.
// cfg_ready is always high.
`default_nettype none

`include "single_wire_sensor_frame_receiver_defines.svh"

module single_wire_sensor_frame_receiver #(
    parameter int FRAME_BYTES = swsfr_pkg::FRAME_BYTES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              evt_valid,
    output logic                                   evt_stall,
    input  wire swsfr_pkg::evt_t                   evt_data,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output swsfr_pkg::res_t                        res_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [swsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                        cfg_data
);

    logic                 evt_accept;
    logic [7:0]           idle_periods_reg;
    logic [7:0]           one_threshold_reg;
    logic                 res_valid_reg;
    swsfr_pkg::res_t      res_data_reg;
    swsfr_pkg::res_t      res_comb;
    swsfr_pkg::frm_ctrl_t fctrl;
    swsfr_pkg::frm_stat_t fstat;
    logic [31:0]          frame_reading;

    assign evt_stall  = res_valid_reg && res_stall;
    assign evt_accept = evt_valid && !evt_stall;
    assign cfg_ready  = 1'b1;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_periods_reg  <= swsfr_pkg::IDLE_PERIODS_RESET;
            one_threshold_reg <= swsfr_pkg::ONE_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swsfr_pkg::CFG_IDLE_PERIODS:  idle_periods_reg  <= cfg_data;
                swsfr_pkg::CFG_ONE_THRESHOLD: one_threshold_reg <= cfg_data;
                default:                      idle_periods_reg  <= idle_periods_reg;
            endcase
        end
    end

    swsfr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (evt_accept),
        .evt           (evt_data),
        .idle_periods  (idle_periods_reg),
        .one_threshold (one_threshold_reg),
        .stat          (fstat),
        .frame_reading (frame_reading),
        .fctrl         (fctrl),
        .res           (res_comb)
    );

    swsfr_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (evt_accept),
        .ctrl    (fctrl),
        .stat    (fstat),
        .reading (frame_reading)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (evt_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            res_data_reg <= res_comb;
        end
    end

    `SWSFR_ASSERT_NOW(a_no_accept_when_full, res_valid_reg && res_stall, !evt_accept,
        "request accepted while the result register is stalled")

    `SWSFR_ASSERT_NOW(a_one_outcome, res_valid_reg,
        $onehot0({res_data_reg.frame_valid, res_data_reg.checksum_fail,
                  res_data_reg.protocol_error}),
        "more than one frame outcome flagged in one result")

    `SWSFR_ASSERT_NOW(a_outcome_goes_idle,
        res_valid_reg && (res_data_reg.frame_valid || res_data_reg.checksum_fail
                          || res_data_reg.protocol_error),
        res_data_reg.timer_mode == swsfr_pkg::TM_IDLE && !res_data_reg.edge_watch
            && !res_data_reg.line_drive_low,
        "frame outcome without return to idle")

    `SWSFR_ASSERT_NOW(a_drive_low_timer,
        res_valid_reg && res_data_reg.line_drive_low,
        !res_data_reg.edge_watch && (res_data_reg.timer_mode == swsfr_pkg::TM_START
                                     || res_data_reg.timer_mode == swsfr_pkg::TM_KEEP),
        "line driven low with a wrong timer command")

endmodule

`default_nettype wire

[bench/sensor_result_checker.sv]
// Checker that predicts and compares every result of the single-wire sensor frame receiver.
`timescale 1ns / 1ps

module sensor_result_checker
    import swsfr_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    input  logic                   evt_stall,
    input  evt_t                   evt_data,
    input  logic                   res_valid,
    input  logic                   res_stall,
    input  res_t                   res_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;

    // Our own copy of the registers and of the receiver state.
    logic [7:0]            idle_periods;
    logic [7:0]            one_threshold;
    phase_t                phase;
    logic [7:0]            idle_left;
    logic [5:0]            bits_taken;
    logic                  frame_done;
    logic [FRAME_BITS-1:0] frame_shift;

    res_t expected_results[$];
    int   fail_count;

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s is %0h, expected %0h", $time, field, got, want);
        fail_count++;
    endtask

    function automatic logic [1:0] return_to_idle();
        phase = PH_WAIT;
        idle_left = idle_periods;
        return TM_IDLE;
    endfunction

    function automatic res_t predict_sensor_result(evt_t e);
        res_t        r;
        logic        ok;
        logic [7:0]  sum;
        logic [63:0] wide;
        int unsigned taken_next;
        r = '0;
        r.timer_mode = TM_KEEP;
        case (e.func)
            FUNC_START:
            begin
                if (phase == PH_WAIT)
                    r.timer_mode = return_to_idle();
            end
            FUNC_TIMER:
            begin
                if (phase == PH_WAIT)
                begin
                    idle_left = idle_left - 8'd1;
                    if (idle_left == 8'd0)
                    begin
                        phase = PH_OUT_LOW;
                        r.timer_mode = TM_START;
                    end
                end
                else if (phase == PH_OUT_LOW)
                begin
                    phase = PH_OUT_HIGH;
                    r.timer_mode = TM_EDGE;
                end
                else
                begin
                    r.protocol_error = 1'b1;
                    r.timer_mode = return_to_idle();
                end
            end
            FUNC_EDGE:
            begin
                ok = 1'b0;
                case (phase)
                    PH_OUT_HIGH:
                    begin
                        if (!e.line_level)
                        begin
                            phase = PH_IN_LOW;
                            r.timer_mode = TM_EDGE;
                            ok = 1'b1;
                        end
                    end
                    PH_IN_LOW:
                    begin
                        if (e.line_level)
                        begin
                            phase = PH_IN_HIGH;
                            r.timer_mode = TM_EDGE;
                            ok = 1'b1;
                        end
                    end
                    PH_IN_HIGH:
                    begin
                        if (!e.line_level)
                        begin
                            bits_taken = '0;
                            frame_done = 1'b0;
                            phase = PH_DATA_LOW;
                            r.timer_mode = TM_EDGE;
                            ok = 1'b1;
                        end
                    end
                    PH_DATA_LOW:
                    begin
                        if (e.line_level)
                        begin
                            ok = 1'b1;
                            if (frame_done)
                            begin
                                // The last byte must equal the byte sum of the others.
                                sum = '0;
                                for (int i = 0; i < FRAME_BYTES - 1; i++)
                                    sum = sum + frame_shift[8 * (FRAME_BYTES - 1 - i) +: 8];
                                if (sum == frame_shift[7:0])
                                    r.frame_valid = 1'b1;
                                else
                                    r.checksum_fail = 1'b1;
                                wide = 64'(frame_shift);
                                if (FRAME_BYTES >= 4)
                                    wide = wide >> (8 * (FRAME_BYTES - 4));
                                else
                                    wide = wide << (8 * (4 - FRAME_BYTES));
                                r.reading = wide[31:0];
                                r.timer_mode = return_to_idle();
                            end
                            else
                            begin
                                phase = PH_DATA_HIGH;
                                r.timer_mode = TM_EDGE;
                            end
                        end
                    end
                    PH_DATA_HIGH:
                    begin
                        if (!e.line_level)
                        begin
                            frame_shift = {frame_shift[FRAME_BITS-2:0],
                                           e.edge_time >= one_threshold};
                            taken_next = bits_taken + 1;
                            if (taken_next >= FRAME_BITS)
                            begin
                                bits_taken = '0;
                                frame_done = 1'b1;
                            end
                            else
                                bits_taken = taken_next[5:0];
                            phase = PH_DATA_LOW;
                            r.timer_mode = TM_EDGE;
                            ok = 1'b1;
                        end
                    end
                    default:
                        ok = 1'b0;
                endcase
                if (!ok)
                begin
                    r.protocol_error = 1'b1;
                    r.timer_mode = return_to_idle();
                end
            end
            default:
                r.timer_mode = TM_KEEP;
        endcase
        r.line_drive_low = (phase == PH_OUT_LOW);
        r.edge_watch = (phase >= PH_OUT_HIGH) && (phase <= PH_DATA_HIGH);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            idle_periods = IDLE_PERIODS_RESET;
            one_threshold = ONE_THRESHOLD_RESET;
            phase = PH_WAIT;
            idle_left = '0;
            bits_taken = '0;
            frame_done = 1'b0;
            frame_shift = '0;
            expected_results.delete();
            fail_count = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing expected", res_data.reading, 32'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.line_drive_low !== want.line_drive_low)
                        report_mismatch("line_drive_low", 32'(res_data.line_drive_low),
                                        32'(want.line_drive_low));
                    if (res_data.timer_mode !== want.timer_mode)
                        report_mismatch("timer_mode", 32'(res_data.timer_mode),
                                        32'(want.timer_mode));
                    if (res_data.edge_watch !== want.edge_watch)
                        report_mismatch("edge_watch", 32'(res_data.edge_watch),
                                        32'(want.edge_watch));
                    if (res_data.frame_valid !== want.frame_valid)
                        report_mismatch("frame_valid", 32'(res_data.frame_valid),
                                        32'(want.frame_valid));
                    if (res_data.reading !== want.reading)
                        report_mismatch("reading", res_data.reading, want.reading);
                    if (res_data.checksum_fail !== want.checksum_fail)
                        report_mismatch("checksum_fail", 32'(res_data.checksum_fail),
                                        32'(want.checksum_fail));
                    if (res_data.protocol_error !== want.protocol_error)
                        report_mismatch("protocol_error", 32'(res_data.protocol_error),
                                        32'(want.protocol_error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDLE_PERIODS:  idle_periods = cfg_data;
                    CFG_ONE_THRESHOLD: one_threshold = cfg_data;
                    default:           idle_periods = idle_periods;
                endcase
            end
            if (evt_valid && !evt_stall)
                expected_results.push_back(predict_sensor_result(evt_data));
            mismatches <= fail_count;
            pending <= expected_results.size();
        end
    end

endmodule

[bench/tb_single_wire_sensor_frame_receiver.sv]
// Testbench top: drives sensor events and register writes and gives the verdict.
`timescale 1ns / 1ps

module tb_single_wire_sensor_frame_receiver;

    import swsfr_pkg::*;

    localparam int FB = FRAME_BYTES_DEFAULT;
    localparam int TARGET_REQUESTS = 1650;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   evt_valid;
    logic                   evt_stall;
    evt_t                   evt_data;
    logic                   res_valid;
    logic                   res_stall;
    res_t                   res_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;
    int                     mismatches;
    int                     pending;

    int         sent = 0;
    int         taken = 0;
    logic [7:0] idle_now = IDLE_PERIODS_RESET;
    logic [7:0] threshold_now = ONE_THRESHOLD_RESET;

    single_wire_sensor_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_data  (evt_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sensor_result_checker results_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt_data   (evt_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic evt_t sensor_event(logic [1:0] kind, logic level, logic [7:0] count);
        evt_t e;
        e.func = kind;
        e.line_level = level;
        e.edge_time = count;
        return e;
    endfunction

    // Returns at the edge where the request was taken, with valid still high.
    task automatic send_event(evt_t e);
        int gap;
        gap = ((sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt_data <= e;
        do
            @(posedge clk);
        while (evt_stall);
        sent++;
    endtask

    task automatic drain();
        int waited;
        evt_valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDLE_PERIODS)
            idle_now = value;
        else
            threshold_now = value;
    endtask

    function automatic logic [7:0] bit_time(logic one);
        if (one)
            return ($urandom_range(0, 7) == 0) ? threshold_now
                                               : 8'($urandom_range(threshold_now, 255));
        if (threshold_now == 0)
            return 8'($urandom_range(0, 255));
        return ($urandom_range(0, 7) == 0) ? threshold_now - 8'd1
                                           : 8'($urandom_range(0, threshold_now - 1));
    endfunction

    // One complete reading, sometimes cut short by a stray request. A stray request
    // is followed by high, low, low edges, which bring the block back to idle from
    // wherever it was left.
    task automatic run_reading();
        evt_t       seq[$];
        logic [7:0] frame_bytes[FB];
        logic [7:0] sum;
        int         cut;
        sum = '0;
        for (int i = 0; i < FB - 1; i++)
        begin
            frame_bytes[i] = 8'($urandom_range(0, 255));
            sum = sum + frame_bytes[i];
        end
        frame_bytes[FB-1] = ($urandom_range(0, 5) == 0) ? sum + 8'($urandom_range(1, 255))
                                                        : sum;
        seq.push_back(sensor_event(FUNC_START, 1'($urandom_range(0, 1)),
                                   8'($urandom_range(0, 255))));
        for (int i = 0; i <= idle_now; i++)
            seq.push_back(sensor_event(FUNC_TIMER, 1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255))));
        seq.push_back(sensor_event(FUNC_EDGE, 1'b0, 8'($urandom_range(0, 255))));
        seq.push_back(sensor_event(FUNC_EDGE, 1'b1, 8'($urandom_range(0, 255))));
        seq.push_back(sensor_event(FUNC_EDGE, 1'b0, 8'($urandom_range(0, 255))));
        for (int i = 0; i < FB; i++)
            for (int b = 7; b >= 0; b--)
            begin
                seq.push_back(sensor_event(FUNC_EDGE, 1'b1, 8'($urandom_range(0, 255))));
                seq.push_back(sensor_event(FUNC_EDGE, 1'b0, bit_time(frame_bytes[i][b])));
            end
        seq.push_back(sensor_event(FUNC_EDGE, 1'b1, 8'($urandom_range(0, 255))));
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(0, seq.size() - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
            seq.push_back(sensor_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 255))));
            seq.push_back(sensor_event(FUNC_EDGE, 1'b1, 8'($urandom_range(0, 255))));
            seq.push_back(sensor_event(FUNC_EDGE, 1'b0, 8'($urandom_range(0, 255))));
            seq.push_back(sensor_event(FUNC_EDGE, 1'b0, 8'($urandom_range(0, 255))));
        end
        foreach (seq[i])
            send_event(seq[i]);
    endtask

    // Result side: a random stall before each result is taken, with calm stretches.
    initial
    begin
        int hold;
        res_stall <= 1'b0;
        forever
        begin
            hold = ((taken / 130) % 4 == 1) ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            taken++;
        end
    end

    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [7:0] idle_plan[4];
        logic [7:0] threshold_plan[4];
        int         reading_plan[4];
        idle_plan = '{8'd1, 8'd255, 8'd13, 8'd2};
        threshold_plan = '{8'd0, 8'd255, 8'd48, 8'd1};
        reading_plan = '{3, 1, 3, 2};
        rst_n <= 1'b0;
        evt_valid <= 1'b0;
        evt_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDLE_PERIODS;
        cfg_data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle cases at the reset settings: the first expiry wraps the idle counter,
        // event kind 3 is ignored, edges while idle are errors, start reloads.
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(2'd3, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_EDGE, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_EDGE, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_START, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_START, 1'b0, 8'h00));

        // Busy cases with one idle period per reading.
        write_register(CFG_IDLE_PERIODS, 8'd1);
        send_event(sensor_event(FUNC_START, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_START, 1'b1, 8'hFF));
        send_event(sensor_event(2'd3, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_EDGE, 1'b0, 8'h80));
        send_event(sensor_event(FUNC_TIMER, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_TIMER, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h7F));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_EDGE, 1'b1, 8'hFF));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_TIMER, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_EDGE, 1'b0, 8'h00));
        send_event(sensor_event(FUNC_EDGE, 1'b0, 8'hFF));

        for (int p = 0; p < 4; p++)
        begin
            write_register(CFG_IDLE_PERIODS, idle_plan[p]);
            write_register(CFG_ONE_THRESHOLD, threshold_plan[p]);
            for (int n = 0; n < reading_plan[p]; n++)
                run_reading();
        end

        while (sent < TARGET_REQUESTS)
        begin
            write_register(CFG_IDLE_PERIODS, ($urandom_range(0, 7) == 0)
                                             ? 8'($urandom_range(9, 40))
                                             : 8'($urandom_range(1, 6)));
            write_register(CFG_ONE_THRESHOLD, 8'($urandom_range(0, 255)));
            for (int n = 0; n < 2; n++)
                run_reading();
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/swsfr_pkg.sv
rtl/swsfr_frame.sv
rtl/swsfr_ctrl.sv
rtl/single_wire_sensor_frame_receiver.sv
bench/sensor_result_checker.sv
bench/tb_single_wire_sensor_frame_receiver.sv
